@@ src/ftlm_pkg.sv @@
// ----------------------------------------------------------------------------
// ftlm_pkg
// Shared types and constants of the three-level fuzzy membership block.
// ----------------------------------------------------------------------------
`default_nettype none

package ftlm_pkg;

    localparam int DATA_WIDTH  = 16;
    localparam int FRAC_BITS   = 15;
    localparam int MAG_W       = DATA_WIDTH + 1;
    localparam int MEM_W       = 16;
    localparam int CLASS_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ATTR_MIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_QUARTILE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_QUARTILE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTR_MAX      = 2'd3;

    typedef struct packed {
        logic [CLASS_W-1:0]           class_label;
        logic signed [DATA_WIDTH-1:0] sample_value;
        logic                         last_in;
    } sample_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_out;
        logic [MEM_W-1:0]   mem_low;
        logic [MEM_W-1:0]   mem_medium;
        logic [MEM_W-1:0]   mem_high;
        logic               last_out;
    } result_t;

    // how a membership is formed from the quotient of its lane
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_Q,
        SEL_INV
    } sel_t;

    typedef struct packed {
        logic             force_zero;
        logic             force_one;
        logic [MAG_W-1:0] num;
        logic [MAG_W-1:0] den;
    } lane_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_label;
        logic               last;
        sel_t               lo_sel;
        sel_t               me_sel;
        sel_t               hi_sel;
        lane_t              mid_lane;
        lane_t              high_lane;
    } work_t;

    typedef struct packed {
        logic push;
        logic full;
    } qwr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } qrd_t;

endpackage

`default_nettype wire

@@ src/ftlm_front.sv @@
// ----------------------------------------------------------------------------
// ftlm_front
// Breakpoint registers, knee derivation and region classification of samples.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlm_front
    import ftlm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire sample_t               sample,
    input  wire logic                  full,
    output qwr_t                       qwr,
    output work_t                      push_word
);

    logic signed [DATA_WIDTH-1:0] attr_min_reg, low_q_reg, high_q_reg, attr_max_reg;
    logic signed [DATA_WIDTH-1:0] ml, md, mh;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [MAG_W-1:0]      dx_ml, dx_md, dx_a, d_r, d_f, d_h;
    logic                         le_ml, le_md, ge_ml, lt_md, lt_mh, le_mh;
    logic                         rising, falling;

    function automatic logic signed [DATA_WIDTH-1:0] half_floor(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic signed [MAG_W-1:0] s;
        s = MAG_W'(a) + MAG_W'(b);
        return s[MAG_W-1:1];
    endfunction

    function automatic lane_t make_lane(
        input logic signed [MAG_W-1:0] n,
        input logic signed [MAG_W-1:0] d
    );
        lane_t l;
        logic [MAG_W-1:0] an, ad;
        an = n[MAG_W-1] ? MAG_W'(-n) : MAG_W'(n);
        ad = d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
        l.num        = an;
        l.den        = ad;
        l.force_zero = (n == '0) || (n[MAG_W-1] != d[MAG_W-1]);
        l.force_one  = !l.force_zero && (an >= ad);
        return l;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_min_reg <= '0;
            low_q_reg    <= '0;
            high_q_reg   <= '0;
            attr_max_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ATTR_MIN:      attr_min_reg <= cfg_data;
                    REG_LOW_QUARTILE:  low_q_reg    <= cfg_data;
                    REG_HIGH_QUARTILE: high_q_reg   <= cfg_data;
                    REG_ATTR_MAX:      attr_max_reg <= cfg_data;
                endcase
            end
        end
    end

    always_comb
    begin
        ml = half_floor(attr_min_reg, low_q_reg);
        md = half_floor(low_q_reg, high_q_reg);
        mh = half_floor(high_q_reg, attr_max_reg);
    end

    assign x     = sample.sample_value;
    assign dx_ml = MAG_W'(x) - MAG_W'(ml);
    assign dx_md = MAG_W'(x) - MAG_W'(md);
    assign dx_a  = MAG_W'(x) - MAG_W'(attr_min_reg);
    assign d_r   = MAG_W'(md) - MAG_W'(ml);
    assign d_f   = MAG_W'(mh) - MAG_W'(md);
    assign d_h   = MAG_W'(mh) - MAG_W'(attr_min_reg);

    assign le_ml = x <= ml;
    assign ge_ml = x >= ml;
    assign le_md = x <= md;
    assign lt_md = x < md;
    assign lt_mh = x < mh;
    assign le_mh = x <= mh;

    assign rising  = ge_ml && le_md;
    assign falling = !le_md && le_mh;

    always_comb
    begin
        push_word.class_label = sample.class_label;
        push_word.last        = sample.last_in;
        // the low ramp and the medium rising ramp share one quotient
        push_word.mid_lane    = rising ? make_lane(dx_ml, d_r) : make_lane(dx_md, d_f);
        push_word.high_lane   = make_lane(dx_a, d_h);

        if (le_ml)
            push_word.lo_sel = SEL_ONE;
        else if (le_md)
            push_word.lo_sel = (d_r == '0) ? SEL_ONE : SEL_INV;
        else
            push_word.lo_sel = SEL_ZERO;

        if (rising)
            push_word.me_sel = (d_r == '0) ? SEL_ZERO : SEL_Q;
        else if (falling)
            push_word.me_sel = (d_f == '0) ? SEL_ONE : SEL_INV;
        else
            push_word.me_sel = SEL_ZERO;

        if (lt_md)
            push_word.hi_sel = SEL_ZERO;
        else if (lt_mh)
            push_word.hi_sel = (d_h == '0) ? SEL_ZERO : SEL_Q;
        else
            push_word.hi_sel = SEL_ONE;
    end

    assign sample_stall = full;

    always_comb
    begin
        qwr.full = full;
        qwr.push = sample_valid && !full;
    end

endmodule

`default_nettype wire

@@ src/ftlm_queue.sv @@
// ----------------------------------------------------------------------------
// ftlm_queue
// Short queue of classified words between the front and the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlm_queue
    import ftlm_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire qwr_t  qwr_in,
    output logic       full,
    input  wire work_t push_word,
    input  wire qrd_t  qrd_in,
    output logic       empty,
    output work_t      head_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    work_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign head_word = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (qwr_in.push && !qrd_in.pop)
            count_next = count_reg + 1'b1;
        else if (!qwr_in.push && qrd_in.pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (qwr_in.push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (qwr_in.push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (qrd_in.pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) qrd_in.pop |-> !empty)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) qwr_in.push |-> !full)
        else $error("push into full queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (qwr_in.push && !qrd_in.pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count lost a word");

endmodule

`default_nettype wire

@@ src/ftlm_back.sv @@
// ----------------------------------------------------------------------------
// ftlm_back
// Pipelined restoring dividers, one quotient bit per stage, and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ftlm_back
    import ftlm_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire work_t head_word,
    input  wire logic  empty,
    output qrd_t       qrd,
    output logic       result_valid,
    input  wire logic  result_stall,
    output result_t    result
);

    localparam int MW = (FRAC + 1 > MEM_W) ? FRAC + 1 : MEM_W;
    localparam logic [MW-1:0] ONE_Q = MW'(1) << FRAC;

    typedef struct packed {
        logic             force_zero;
        logic             force_one;
        logic [MAG_W-1:0] rem;
        logic [MAG_W-1:0] den;
        logic [FRAC-1:0]  quo;
    } div_t;

    typedef struct packed {
        logic [CLASS_W-1:0] class_label;
        logic               last;
        sel_t               lo_sel;
        sel_t               me_sel;
        sel_t               hi_sel;
        div_t               mid_div;
        div_t               high_div;
    } stage_t;

    stage_t           st_reg [FRAC];
    stage_t           st_in  [FRAC];
    logic [FRAC-1:0]  v_reg;
    logic             out_valid_reg;
    result_t          result_reg, result_next;
    logic             adv;
    stage_t           head_st;

    function automatic div_t div_start(input lane_t l);
        div_t d;
        d.force_zero = l.force_zero;
        d.force_one  = l.force_one;
        d.rem        = l.num;
        d.den        = l.den;
        d.quo        = '0;
        return d;
    endfunction

    function automatic div_t div_step(input div_t d);
        div_t o;
        logic [MAG_W:0] r2;
        o  = d;
        r2 = {d.rem, 1'b0};
        if (r2 >= {1'b0, d.den})
        begin
            o.rem = MAG_W'(r2 - {1'b0, d.den});
            o.quo = {d.quo[FRAC-2:0], 1'b1};
        end
        else
        begin
            o.rem = r2[MAG_W-1:0];
            o.quo = {d.quo[FRAC-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic stage_t stage_step(input stage_t s);
        stage_t o;
        o          = s;
        o.mid_div  = div_step(s.mid_div);
        o.high_div = div_step(s.high_div);
        return o;
    endfunction

    function automatic logic [MEM_W-1:0] form(input sel_t s, input div_t d);
        logic [MW-1:0] q;
        logic [MW-1:0] v;
        if (d.force_one)
            q = ONE_Q;
        else if (d.force_zero)
            q = '0;
        else
            q = MW'(d.quo);
        unique case (s)
            SEL_ZERO: v = '0;
            SEL_ONE:  v = ONE_Q;
            SEL_Q:    v = q;
            SEL_INV:  v = ONE_Q - q;
        endcase
        return v[MEM_W-1:0];
    endfunction

    // the whole pipeline moves when the result register can take a word
    assign adv = !out_valid_reg || !result_stall;

    always_comb
    begin
        qrd.pop   = adv && !empty;
        qrd.empty = empty;
    end

    always_comb
    begin
        head_st.class_label = head_word.class_label;
        head_st.last        = head_word.last;
        head_st.lo_sel      = head_word.lo_sel;
        head_st.me_sel      = head_word.me_sel;
        head_st.hi_sel      = head_word.hi_sel;
        head_st.mid_div     = div_start(head_word.mid_lane);
        head_st.high_div    = div_start(head_word.high_lane);
    end

    genvar k;
    generate
        for (k = 0; k < FRAC; k++)
        begin : g_stage
            if (k == 0)
            begin : g_first
                assign st_in[k] = head_st;
            end
            else
            begin : g_rest
                assign st_in[k] = st_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                    st_reg[k] <= stage_step(st_in[k]);
            end
        end
    endgenerate

    always_comb
    begin
        result_next.class_out  = st_reg[FRAC-1].class_label;
        result_next.last_out   = st_reg[FRAC-1].last;
        result_next.mem_low    = form(st_reg[FRAC-1].lo_sel, st_reg[FRAC-1].mid_div);
        result_next.mem_medium = form(st_reg[FRAC-1].me_sel, st_reg[FRAC-1].mid_div);
        result_next.mem_high   = form(st_reg[FRAC-1].hi_sel, st_reg[FRAC-1].high_div);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[FRAC-2:0], qrd.pop};
            out_valid_reg <= v_reg[FRAC-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n) qrd.pop |=> v_reg[0])
        else $error("popped word did not enter the divider pipeline");

endmodule

`default_nettype wire

@@ src/fuzzy_three_level_membership.sv @@
// ----------------------------------------------------------------------------
// fuzzy_three_level_membership
// Three-level fuzzifier: low, medium and high memberships of one sample.
// ----------------------------------------------------------------------------
// Takes one sample word per cycle unless sample_stall holds it off, and returns
// one result word per sample, in order, each membership in unsigned Q1.FRAC
// (1 << FRAC is one). Throughput is one word per clock while result_stall is
// low; the restoring dividers resolve one quotient bit per pipeline stage.
// A breakpoint write applies to every sample accepted after it.
`default_nettype none

module fuzzy_three_level_membership
    import ftlm_pkg::*;
#(
    parameter int FRAC = FRAC_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DATA_WIDTH-1:0] cfg_data,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire sample_t               sample,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output result_t                    result
);

    qwr_t  qwr;
    qrd_t  qrd;
    work_t push_word, head_word;
    logic  full, empty;
    qwr_t  qwr_q;

    ftlm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .full         (full),
        .qwr          (qwr),
        .push_word    (push_word)
    );

    always_comb
    begin
        qwr_q.push = qwr.push;
        qwr_q.full = full;
    end

    ftlm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .qwr_in    (qwr_q),
        .full      (full),
        .push_word (push_word),
        .qrd_in    (qrd),
        .empty     (empty),
        .head_word (head_word)
    );

    ftlm_back #(
        .FRAC (FRAC)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_word    (head_word),
        .empty        (empty),
        .qrd          (qrd),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ verif/fuzzy_three_level_membership_test.sv @@
// ----------------------------------------------------------------------------
// fuzzy_three_level_membership_test
// Self-checking bench for the three-level fuzzifier.
// ----------------------------------------------------------------------------
// Breakpoint registers are programmed while the block is idle. Sample words
// are then streamed with random gaps and random result stalls. Every result
// word is checked field by field against memberships computed here from the
// same breakpoints. Directed tests cover the edge cases: ordered, equal and
// unordered breakpoints, the full-scale extremes, and samples at and around
// each knee. Random tests follow.
`default_nettype none

module fuzzy_three_level_membership_test;
    import ftlm_pkg::*;

    localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
    localparam int     LATENCY = FRAC_BITS + 1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [DATA_WIDTH-1:0] cfg_data;
    logic                  sample_valid;
    logic                  sample_stall;
    sample_t               sample;
    logic                  result_valid;
    logic                  result_stall;
    result_t               result;

    fuzzy_three_level_membership u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // breakpoint copies, in register index order
    logic signed [DATA_WIDTH-1:0] bp [4];
    result_t expected_words [$];
    int      mismatches;
    int      samples_sent;
    int      words_checked;
    bit      stall_enable;
    int      stall_left;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("fuzzy_three_level_membership_test: errors");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        else if (r < 95)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic longint knee(longint a, longint b);
        longint s;
        s = a + b;
        if (s >= 0)
            return s / 2;
        return -((-s + 1) / 2);
    endfunction

    // n*one/d truncated, clamped to 0..one
    function automatic longint ratio_q(longint n, longint d);
        longint un;
        longint ud;
        if (n == 0)
            return 0;
        if ((n < 0) != (d < 0))
            return 0;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        if (un >= ud)
            return ONE_Q;
        return (un * ONE_Q) / ud;
    endfunction

    function automatic result_t memberships(sample_t s);
        result_t r;
        longint  x;
        longint  amin;
        longint  ml;
        longint  md;
        longint  mh;
        longint  lo;
        longint  me;
        longint  hi;
        x    = longint'(s.sample_value);
        amin = longint'(bp[REG_ATTR_MIN]);
        ml   = knee(amin, longint'(bp[REG_LOW_QUARTILE]));
        md   = knee(longint'(bp[REG_LOW_QUARTILE]), longint'(bp[REG_HIGH_QUARTILE]));
        mh   = knee(longint'(bp[REG_HIGH_QUARTILE]), longint'(bp[REG_ATTR_MAX]));
        if (x <= ml)
            lo = ONE_Q;
        else if (x <= md)
            lo = (md == ml) ? ONE_Q : ONE_Q - ratio_q(x - ml, md - ml);
        else
            lo = 0;
        if (x >= ml && x <= md)
            me = (md == ml) ? 0 : ratio_q(x - ml, md - ml);
        else if (x > md && x <= mh)
            me = (mh == md) ? ONE_Q : ONE_Q - ratio_q(x - md, mh - md);
        else
            me = 0;
        if (x < md)
            hi = 0;
        else if (x < mh)
            hi = (mh == amin) ? 0 : ratio_q(x - amin, mh - amin);
        else
            hi = ONE_Q;
        r.class_out  = s.class_label;
        r.mem_low    = lo[MEM_W-1:0];
        r.mem_medium = me[MEM_W-1:0];
        r.mem_high   = hi[MEM_W-1:0];
        r.last_out   = s.last_in;
        return r;
    endfunction

    // result stall: mostly low, short and occasional long holds
    always @(negedge clk)
    begin
        if (!stall_enable)
            result_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left   <= gap_len();
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word %h", result);
                mismatches++;
            end
            else
            begin
                result_t e;
                e = expected_words.pop_front();
                words_checked++;
                if (result.class_out !== e.class_out)
                begin
                    $error("class_out expected %0d got %0d", e.class_out, result.class_out);
                    mismatches++;
                end
                if (result.mem_low !== e.mem_low)
                begin
                    $error("mem_low expected %0d got %0d", e.mem_low, result.mem_low);
                    mismatches++;
                end
                if (result.mem_medium !== e.mem_medium)
                begin
                    $error("mem_medium expected %0d got %0d", e.mem_medium, result.mem_medium);
                    mismatches++;
                end
                if (result.mem_high !== e.mem_high)
                begin
                    $error("mem_high expected %0d got %0d", e.mem_high, result.mem_high);
                    mismatches++;
                end
                if (result.last_out !== e.last_out)
                begin
                    $error("last_out expected %0d got %0d", e.last_out, result.last_out);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_sample(input logic [7:0] cls, input logic signed [15:0] x,
                               input logic last);
        @(negedge clk);
        sample_valid        = 1'b1;
        sample.class_label  = cls;
        sample.sample_value = x;
        sample.last_in      = last;
        do
            @(posedge clk);
        while (sample_stall);
        expected_words.push_back(memberships(sample));
        samples_sent++;
    endtask

    task automatic idle_cycles(input int n);
        for (int i = 0; i < n; i++)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
        end
    endtask

    task automatic drain();
        idle_cycles(1);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_breakpoints(input logic signed [15:0] amin,
                                     input logic signed [15:0] lq,
                                     input logic signed [15:0] hq,
                                     input logic signed [15:0] amax);
        logic signed [15:0] v [4];
        v[0] = amin;
        v[1] = lq;
        v[2] = hq;
        v[3] = amax;
        drain();
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = CFG_IDX_W'(i);
            cfg_data  = v[i];
            bp[i]     = v[i];
        end
        @(negedge clk);
        cfg_we = 1'b0;
        repeat (2) @(negedge clk);
    endtask

    // samples at and around the knees of the current setting, plus zero and the extremes
    task automatic knee_sweep();
        longint pts [12];
        longint ml;
        longint md;
        longint mh;
        ml = knee(bp[0], bp[1]);
        md = knee(bp[1], bp[2]);
        mh = knee(bp[2], bp[3]);
        pts = '{-32768, 32767, 0, ml - 1, ml, ml + 1, md - 1, md, md + 1,
                mh - 1, mh, mh + 1};
        foreach (pts[i])
        begin
            if (pts[i] >= -32768 && pts[i] <= 32767)
                send_sample(8'($urandom), 16'(pts[i]), 1'(i == 11));
            idle_cycles(gap_len() % 3);
        end
    endtask

    task automatic test_reset_defaults();
        knee_sweep();
    endtask

    task automatic test_directed_settings();
        write_breakpoints(-30000, -10000, 10000, 30000);
        knee_sweep();
        send_sample(8'hff, 16'sh7fff, 1'b1);
        send_sample(8'h00, 16'sh8000, 1'b0);
        // extremes of the range, full-scale spans
        write_breakpoints(-32768, -32768, 32767, 32767);
        knee_sweep();
        // equal knees, so every span collapses
        write_breakpoints(100, 100, 100, 100);
        knee_sweep();
        // unordered breakpoints
        write_breakpoints(32767, 5000, -5000, -32768);
        knee_sweep();
    endtask

    task automatic test_random(input int sets, input int per_set);
        logic signed [15:0] v [4];
        int                 style;
        for (int s = 0; s < sets; s++)
        begin
            style = $urandom_range(0, 9);
            for (int i = 0; i < 4; i++)
                v[i] = 16'($urandom);
            if (style < 7)
                v.sort();
            else if (style == 7)
                v[1] = v[0];
            write_breakpoints(v[0], v[1], v[2], v[3]);
            stall_enable = (s % 4 != 3);
            for (int n = 0; n < per_set; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_sample(8'($urandom), 16'($urandom_range(0, 65535)),
                                1'(n == per_set - 1));
                else
                    send_sample(8'($urandom),
                                16'(v[$urandom_range(0, 3)] + $signed($urandom_range(0, 64)) - 32),
                                1'(n == per_set - 1));
                if (s % 4 != 3)
                    idle_cycles(gap_len());
                if (n == per_set / 2 && s % 5 == 0)
                    drain();
            end
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        sample_valid = 1'b0;
        sample       = '0;
        result_stall = 1'b0;
        stall_enable = 1'b1;
        stall_left   = 0;
        mismatches   = 0;
        samples_sent = 0;
        words_checked = 0;
        foreach (bp[i])
            bp[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_directed_settings();
        test_random(20, 40);
        drain();

        $display("sent %0d sample words over many breakpoint settings, checked %0d results",
                 samples_sent, words_checked);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("fuzzy_three_level_membership_test: clean");
        else
            $display("fuzzy_three_level_membership_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
